// ===== rtl/core/lwpb_pkg.sv =====
// ----------------------------------------------------------------------------
// lwpb_pkg
// Shared widths, register indexes and types of the luma wipe pixel blender.
// ----------------------------------------------------------------------------
`default_nettype none

package lwpb_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 18;
    localparam int SOFT_W   = 17;
    localparam int BYTE_W   = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_POS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_POS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFTNESS   = 2'd2;

    // Where the position falls against the ramp [weight, weight + softness).
    typedef enum logic [1:0] {
        MIX_ZERO,
        MIX_FULL,
        MIX_RAMP
    } mix_class_t;

    // Data that rides along the pipeline next to the mix computation.
    typedef struct packed {
        mix_class_t          cls;
        logic [BYTE_W-1:0]   in_luma;
        logic [BYTE_W-1:0]   in_chroma;
        logic [BYTE_W-1:0]   out_luma;
        logic [BYTE_W-1:0]   out_chroma;
    } pix_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/lwpb_in_if.sv =====
// ----------------------------------------------------------------------------
// lwpb_in_if
// Pixel input channel: luma-map weight, field bit and both frames' bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwpb_in_if;
    logic                            valid;
    logic                            ready;
    logic [lwpb_pkg::WEIGHT_W-1:0]   map_weight;
    logic                            field_select;
    logic [lwpb_pkg::BYTE_W-1:0]     incoming_luma_byte;
    logic [lwpb_pkg::BYTE_W-1:0]     incoming_chroma_byte;
    logic [lwpb_pkg::BYTE_W-1:0]     outgoing_luma_byte;
    logic [lwpb_pkg::BYTE_W-1:0]     outgoing_chroma_byte;

    modport source (
        output valid, map_weight, field_select,
        output incoming_luma_byte, incoming_chroma_byte,
        output outgoing_luma_byte, outgoing_chroma_byte,
        input  ready
    );

    modport sink (
        input  valid, map_weight, field_select,
        input  incoming_luma_byte, incoming_chroma_byte,
        input  outgoing_luma_byte, outgoing_chroma_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/lwpb_out_if.sv =====
// ----------------------------------------------------------------------------
// lwpb_out_if
// Blended pixel output channel: two mixed YUV422 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwpb_out_if;
    logic                          valid;
    logic                          ready;
    logic [lwpb_pkg::BYTE_W-1:0]   mixed_luma_byte;
    logic [lwpb_pkg::BYTE_W-1:0]   mixed_chroma_byte;

    modport source (
        output valid, mixed_luma_byte, mixed_chroma_byte,
        input  ready
    );

    modport sink (
        input  valid, mixed_luma_byte, mixed_chroma_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/lwpb_div_step.sv =====
// ----------------------------------------------------------------------------
// lwpb_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpb_div_step #(
    parameter int FRAC_BITS = lwpb_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [lwpb_pkg::SOFT_W-1:0]   divisor,
    input  wire logic [lwpb_pkg::SOFT_W-1:0]   rem_in,
    input  wire logic [FRAC_BITS-1:0]          quo_in,
    input  wire lwpb_pkg::pix_side_t           side_in,
    output logic      [lwpb_pkg::SOFT_W-1:0]   rem_out,
    output logic      [FRAC_BITS-1:0]          quo_out,
    output lwpb_pkg::pix_side_t                side_out
);
    import lwpb_pkg::*;

    // remainder stays below the divisor, so the doubled value fits one more bit
    logic [SOFT_W:0]   rem_dbl;
    logic              take;
    logic [SOFT_W:0]   rem_sub;
    logic [SOFT_W-1:0] rem_next;
    logic [FRAC_BITS-1:0] quo_next;

    assign rem_dbl  = {rem_in, 1'b0};
    assign take     = (rem_dbl >= {1'b0, divisor});
    assign rem_sub  = rem_dbl - {1'b0, divisor};
    assign rem_next = take ? rem_sub[SOFT_W-1:0] : rem_dbl[SOFT_W-1:0];
    assign quo_next = {quo_in[FRAC_BITS-2:0], take};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            quo_out  <= quo_next;
            side_out <= side_in;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/lwpb_smoothstep.sv =====
// ----------------------------------------------------------------------------
// lwpb_smoothstep
// Two-stage t*t*(3-2t) polynomial and selection of the final mix factor.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpb_smoothstep #(
    parameter int FRAC_BITS = lwpb_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [FRAC_BITS-1:0]   t,
    input  wire lwpb_pkg::pix_side_t    side_in,
    output logic      [FRAC_BITS:0]     mix,
    output lwpb_pkg::pix_side_t         side_out
);
    import lwpb_pkg::*;

    localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   MIX_ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [2*FRAC_BITS-1:0] t_sq;
    logic [FRAC_BITS-1:0]   sq_reg;
    logic [FRAC_BITS+1:0]   slope_reg;
    pix_side_t              side_reg;
    logic [2*FRAC_BITS+1:0] poly;
    logic [FRAC_BITS:0]     mix_next;

    assign t_sq = t * t;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= t_sq[2*FRAC_BITS-1:FRAC_BITS];
            slope_reg <= THREE_ONE - {1'b0, t, 1'b0};
            side_reg  <= side_in;
        end
    end

    assign poly = sq_reg * slope_reg;

    always_comb
    begin
        unique case (side_reg.cls)
            MIX_ZERO: mix_next = '0;
            MIX_FULL: mix_next = MIX_ONE;
            default:  mix_next = poly[2*FRAC_BITS:FRAC_BITS];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mix      <= mix_next;
            side_out <= side_reg;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/lwpb_lane.sv =====
// ----------------------------------------------------------------------------
// lwpb_lane
// One byte lane: out + ((in - out) * mix) >> FRAC_BITS, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpb_lane #(
    parameter int FRAC_BITS = lwpb_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [FRAC_BITS:0]            mix,
    input  wire logic [lwpb_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic [lwpb_pkg::BYTE_W-1:0]   out_byte,
    output logic      [lwpb_pkg::BYTE_W-1:0]   result
);
    import lwpb_pkg::*;

    localparam int PROD_W = FRAC_BITS + BYTE_W + 3;

    logic signed [BYTE_W:0]      delta;
    logic signed [FRAC_BITS+1:0] mix_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_reg;
    logic        [BYTE_W-1:0]    base_reg;

    assign delta = $signed({1'b0, in_byte}) - $signed({1'b0, out_byte});
    assign mix_s = $signed({1'b0, mix});
    assign prod  = delta * mix_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod;
            base_reg <= out_byte;
        end
    end

    // floor shift of the signed term; the sum always lands in 0..255
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result <= base_reg + prod_reg[FRAC_BITS+BYTE_W-1:FRAC_BITS];
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/luma_wipe_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// luma_wipe_pixel_blend
// Luma-map wipe blender: smoothstep mix factor per pixel, two byte lanes.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake          payload
//  --------   ---  -----------------  ----------------------------------------
//  pixel      in   valid / ready      map_weight, field_select, 4 frame bytes
//  blended    out  valid / ready      mixed_luma_byte, mixed_chroma_byte
//  cfg        in   cfg_wr_en only     cfg_index, cfg_data (no read-back)
//
//  One pixel per clock sustained while the output does not stall; the pipeline
//  is the classify stage, the restoring divider (one quotient bit per stage),
//  the two multiplier stages of the polynomial and the two stages of each lane.
//  Reset clears the config registers, the stage valid bits and the skid flag.
//  A stall on the output parks the last result in a skid register; ready then
//  drops for the cycles the skid is full, and the pipeline freezes in place.
//
`default_nettype none

module luma_wipe_pixel_blend #(
    parameter int FRAC_BITS = lwpb_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [lwpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lwpb_pkg::CFG_DATA_W-1:0]    cfg_data,
    lwpb_in_if.sink                                 pixel,
    lwpb_out_if.source                              blended
);
    import lwpb_pkg::*;

    // front stage, FRAC_BITS divider steps, 2 polynomial, 2 lane stages
    localparam int STAGES = FRAC_BITS + 5;

    // ---------------- configuration registers ----------------
    logic [POS_W-1:0]  first_pos_reg;
    logic [POS_W-1:0]  second_pos_reg;
    logic [SOFT_W-1:0] soft_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pos_reg  <= '0;
            second_pos_reg <= '0;
            soft_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FIRST_POS:  first_pos_reg  <= cfg_data[POS_W-1:0];
                REG_SECOND_POS: second_pos_reg <= cfg_data[POS_W-1:0];
                REG_SOFTNESS:   soft_reg       <= cfg_data[SOFT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // The whole pipeline moves together unless the skid register is holding
    // a result; bubbles simply travel with valid low.
    logic              pipe_en;
    logic [STAGES-1:0] valid_reg;
    logic              skid_full_reg;
    logic              skid_full_next;
    logic [BYTE_W-1:0] skid_luma_reg;
    logic [BYTE_W-1:0] skid_chroma_reg;

    assign pipe_en     = !skid_full_reg;
    assign pixel.ready = !skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], pixel.valid};
        end
    end

    // ---------------- front stage: classify against the ramp ----------------
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  weight_ext;
    logic [POS_W-1:0]  ramp_end;
    logic [POS_W-1:0]  offset;
    mix_class_t        cls_next;
    pix_side_t         side_next;
    logic [SOFT_W-1:0] front_rem_reg;
    pix_side_t         front_side_reg;

    assign pos        = pixel.field_select ? second_pos_reg : first_pos_reg;
    assign weight_ext = {{(POS_W-WEIGHT_W){1'b0}}, pixel.map_weight};
    // weight + softness cannot wrap in POS_W bits
    assign ramp_end   = weight_ext + {{(POS_W-SOFT_W){1'b0}}, soft_reg};
    assign offset     = pos - weight_ext;

    // zero softness makes the ramp empty: hard step at the weight
    always_comb
    begin
        priority if (pos < weight_ext)
            cls_next = MIX_ZERO;
        else if (pos >= ramp_end)
            cls_next = MIX_FULL;
        else
            cls_next = MIX_RAMP;
    end

    always_comb
    begin
        side_next.cls        = cls_next;
        side_next.in_luma    = pixel.incoming_luma_byte;
        side_next.in_chroma  = pixel.incoming_chroma_byte;
        side_next.out_luma   = pixel.outgoing_luma_byte;
        side_next.out_chroma = pixel.outgoing_chroma_byte;
    end

    // inside the ramp the offset is below softness, so SOFT_W bits hold it
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            front_rem_reg  <= offset[SOFT_W-1:0];
            front_side_reg <= side_next;
        end
    end

    // ---------------- divider: t = (offset << FRAC_BITS) / softness ----------------
    logic [SOFT_W-1:0]    div_rem  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] div_quo  [0:FRAC_BITS];
    pix_side_t            div_side [0:FRAC_BITS];

    assign div_rem[0]  = front_rem_reg;
    assign div_quo[0]  = '0;
    assign div_side[0] = front_side_reg;

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_div
        lwpb_div_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk      (clk),
            .en       (pipe_en),
            .divisor  (soft_reg),
            .rem_in   (div_rem[k]),
            .quo_in   (div_quo[k]),
            .side_in  (div_side[k]),
            .rem_out  (div_rem[k+1]),
            .quo_out  (div_quo[k+1]),
            .side_out (div_side[k+1])
        );
    end

    // ---------------- smoothstep ----------------
    logic [FRAC_BITS:0] mix;
    pix_side_t          mix_side;

    lwpb_smoothstep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_smoothstep (
        .clk      (clk),
        .en       (pipe_en),
        .t        (div_quo[FRAC_BITS]),
        .side_in  (div_side[FRAC_BITS]),
        .mix      (mix),
        .side_out (mix_side)
    );

    // ---------------- byte lanes ----------------
    logic [BYTE_W-1:0] lane_luma;
    logic [BYTE_W-1:0] lane_chroma;

    lwpb_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_luma (
        .clk      (clk),
        .en       (pipe_en),
        .mix      (mix),
        .in_byte  (mix_side.in_luma),
        .out_byte (mix_side.out_luma),
        .result   (lane_luma)
    );

    lwpb_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_chroma (
        .clk      (clk),
        .en       (pipe_en),
        .mix      (mix),
        .in_byte  (mix_side.in_chroma),
        .out_byte (mix_side.out_chroma),
        .result   (lane_chroma)
    );

    // ---------------- merge and output skid ----------------
    // Skid fills when the last stage holds a result the sink does not take;
    // it drains on the next transfer, then the frozen last stage shows.
    assign skid_full_next = (skid_full_reg || valid_reg[STAGES-1]) && !blended.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_luma_reg   <= lane_luma;
            skid_chroma_reg <= lane_chroma;
        end
    end

    assign blended.valid             = skid_full_reg || valid_reg[STAGES-1];
    assign blended.mixed_luma_byte   = skid_full_reg ? skid_luma_reg   : lane_luma;
    assign blended.mixed_chroma_byte = skid_full_reg ? skid_chroma_reg : lane_chroma;

endmodule

`default_nettype wire
